FILE: rtl/core/hrlhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlhp_pkg
// types, codes and name tables for the http request line and header parser
// ----------------------------------------------------------------------------
package hrlhp_pkg;

    localparam int OUT_TDATA_W = 48;

    typedef enum logic [12:0] {
        S_START        = 13'b0000000000001,
        S_METHOD       = 13'b0000000000010,
        S_URL          = 13'b0000000000100,
        S_PROTO        = 13'b0000000001000,
        S_PROTO_CR     = 13'b0000000010000,
        S_HDR_START    = 13'b0000000100000,
        S_HDR_START_CR = 13'b0000001000000,
        S_KEY          = 13'b0000010000000,
        S_VALUE        = 13'b0000100000000,
        S_VALUE_CR     = 13'b0001000000000,
        S_BODY         = 13'b0010000000000,
        S_COMPLETE     = 13'b0100000000000,
        S_ERROR        = 13'b1000000000000
    } parse_state_t;

    typedef enum logic [3:0] {
        PH_BLANKS = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_REST   = 4'b1000
    } digit_phase_t;

    localparam logic [3:0] STAT_START        = 4'd0;
    localparam logic [3:0] STAT_METHOD       = 4'd1;
    localparam logic [3:0] STAT_URL          = 4'd2;
    localparam logic [3:0] STAT_PROTO        = 4'd3;
    localparam logic [3:0] STAT_PROTO_CR     = 4'd4;
    localparam logic [3:0] STAT_HDR_START    = 4'd5;
    localparam logic [3:0] STAT_HDR_START_CR = 4'd6;
    localparam logic [3:0] STAT_KEY          = 4'd7;
    localparam logic [3:0] STAT_VALUE        = 4'd8;
    localparam logic [3:0] STAT_VALUE_CR     = 4'd9;
    localparam logic [3:0] STAT_BODY         = 4'd10;
    localparam logic [3:0] STAT_COMPLETE     = 4'd11;
    localparam logic [3:0] STAT_ERROR        = 4'd12;

    localparam logic [2:0] TAG_NONE     = 3'd0;
    localparam logic [2:0] TAG_METHOD   = 3'd1;
    localparam logic [2:0] TAG_URL      = 3'd2;
    localparam logic [2:0] TAG_PROTOCOL = 3'd3;
    localparam logic [2:0] TAG_KEY      = 3'd4;
    localparam logic [2:0] TAG_VALUE    = 3'd5;
    localparam logic [2:0] TAG_BODY     = 3'd6;

    localparam logic [2:0] METH_UNKNOWN = 3'd0;

    localparam logic CMD_DATA    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    localparam int          METH_COUNT = 6;
    localparam logic [5:0]  METH_ALL   = 6'b111111;
    localparam logic [3:0]  TOKEN_SAT  = 4'd15;
    localparam logic [3:0]  KEY_LEN    = 4'd14;

    // method names left-justified, index i gives method code i+1
    localparam logic [63:0] METH_WORD [METH_COUNT] = '{
        {"GET",     40'h0},
        {"POST",    32'h0},
        {"PUT",     40'h0},
        {"DELETE",  16'h0},
        {"HEAD",    32'h0},
        {"OPTIONS",  8'h0}
    };
    localparam logic [3:0] METH_LEN [METH_COUNT] = '{
        4'd3, 4'd4, 4'd3, 4'd6, 4'd4, 4'd7
    };

    localparam logic [111:0] KEY_WORD = "content-length";

    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_FF   = 8'h0C;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_UC_A = 8'h41;
    localparam logic [7:0] CH_UC_Z = 8'h5A;

    function automatic logic [7:0] meth_char(input logic [63:0] word, input logic [2:0] pos);
        logic [63:0] sh;
        sh = word << {pos, 3'b000};
        return sh[63:56];
    endfunction

    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [111:0] sh;
        sh = KEY_WORD << {pos, 3'b000};
        return sh[111:104];
    endfunction

    function automatic logic [3:0] status_code(input parse_state_t st);
        logic [3:0] code;
        unique case (st)
            S_START:        code = STAT_START;
            S_METHOD:       code = STAT_METHOD;
            S_URL:          code = STAT_URL;
            S_PROTO:        code = STAT_PROTO;
            S_PROTO_CR:     code = STAT_PROTO_CR;
            S_HDR_START:    code = STAT_HDR_START;
            S_HDR_START_CR: code = STAT_HDR_START_CR;
            S_KEY:          code = STAT_KEY;
            S_VALUE:        code = STAT_VALUE;
            S_VALUE_CR:     code = STAT_VALUE_CR;
            S_BODY:         code = STAT_BODY;
            S_COMPLETE:     code = STAT_COMPLETE;
            default:        code = STAT_ERROR;
        endcase
        return code;
    endfunction

endpackage

FILE: rtl/core/http_request_line_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_line_header_parser
// one byte per transaction http/1.1 request line and header parser with
// method classification, field tagging and content-length decoding
// ----------------------------------------------------------------------------
// Each input transaction carries one request byte, or a restart command on
// s_axis_tuser. The block takes one byte every clock cycle: the whole state
// update for a byte (method match, case-blind key compare, one decimal digit
// step of the length value, body count) is a single pass of logic into the
// state registers, and the result lands in one output register in the cycle
// after the byte is accepted. Throughput is one transaction per cycle as long
// as m_axis_tready is high; while a result waits in the output register,
// s_axis_tready follows m_axis_tready. LENGTH_BITS sets the width of the
// content-length accumulator and body counter; body_length shows its low
// 32 bits.
module http_request_line_header_parser #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // data_byte
    input  logic [0:0]                         s_axis_tuser,  // command
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // parse_status[3:0], field_tag[6:4], field_end[7], method_code[10:8],
    // body_length[42:11], done_res[43], error[44], zero fill [47:45]
    output logic [hrlhp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    import hrlhp_pkg::*;

    localparam int LB = LENGTH_BITS;

    parse_state_t      state_reg, state_next;
    logic [5:0]        cand_reg, cand_next;
    logic [3:0]        tokpos_reg, tokpos_next;
    logic [2:0]        meth_reg, meth_next;
    logic [3:0]        keypos_reg, keypos_next;
    logic              keyok_reg, keyok_next;
    logic              inlen_reg, inlen_next;
    digit_phase_t      phase_reg, phase_next;
    logic [LB-1:0]     acc_reg, acc_next;
    logic              lenbad_reg, lenbad_next;
    logic              lenseen_reg, lenseen_next;
    logic [LB-1:0]     clen_reg, clen_next;
    logic [LB-1:0]     bcnt_reg, bcnt_next;
    logic              broken_reg, broken_next;

    logic              m_valid_reg;
    logic [3:0]        o_status_reg;
    logic [2:0]        o_tag_reg;
    logic              o_fend_reg;
    logic [2:0]        o_meth_reg;
    logic [31:0]       o_blen_reg;
    logic              o_done_reg;
    logic              o_err_reg;

    logic [2:0]        tag;
    logic              fend;
    logic [31:0]       blen;
    logic [31:0]       clen_low;

    logic              s_fire;
    logic [7:0]        b;
    logic [7:0]        lc;
    logic              is_digit;
    logic [LB+3:0]     acc_wide;
    logic              acc_ovf;
    logic [5:0]        cand_base;
    logic [3:0]        tokpos_base;
    logic [5:0]        cand_step;
    logic [2:0]        meth_at_end;
    logic              key_step_ok;
    logic [3:0]        keypos_base;
    logic              keyok_base;
    logic [LB-1:0]     bcnt_inc;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;
    assign lc            = (b >= CH_UC_A && b <= CH_UC_Z) ? (b | 8'h20) : b;
    assign is_digit      = (b >= CH_0) && (b <= CH_9);

    // length * 10 + digit, overflow when anything lands above LB bits
    assign acc_wide = ({4'b0000, acc_reg} << 3) + ({4'b0000, acc_reg} << 1)
                    + {{(LB){1'b0}}, 4'(b - CH_0)};
    assign acc_ovf  = |acc_wide[LB+3:LB];

    assign bcnt_inc = bcnt_reg + {{(LB-1){1'b0}}, 1'b1};

    generate
        if (LB >= 32) begin : g_clen_wide
            assign clen_low = clen_next[31:0];
        end else begin : g_clen_narrow
            assign clen_low = {{(32-LB){1'b0}}, clen_next};
        end
    endgenerate

    // method candidate filter for one token byte
    always_comb begin
        cand_base   = (state_reg == S_START) ? METH_ALL : cand_reg;
        tokpos_base = (state_reg == S_START) ? 4'd0 : tokpos_reg;
        cand_step   = cand_base;
        for (int i = 0; i < METH_COUNT; i++) begin
            if (tokpos_base >= METH_LEN[i] ||
                meth_char(METH_WORD[i], tokpos_base[2:0]) != b) begin
                cand_step[i] = 1'b0;
            end
        end
        meth_at_end = METH_UNKNOWN;
        for (int i = 0; i < METH_COUNT; i++) begin
            if (cand_reg[i] && tokpos_reg == METH_LEN[i]) begin
                meth_at_end = 3'(i + 1);
            end
        end
    end

    // header key compare against content-length
    always_comb begin
        keypos_base = (state_reg == S_HDR_START) ? 4'd0 : keypos_reg;
        keyok_base  = (state_reg == S_HDR_START) ? 1'b1 : keyok_reg;
        key_step_ok = keyok_base && (keypos_base < KEY_LEN) && (key_char(keypos_base) == lc);
    end

    always_comb begin
        state_next   = state_reg;
        cand_next    = cand_reg;
        tokpos_next  = tokpos_reg;
        meth_next    = meth_reg;
        keypos_next  = keypos_reg;
        keyok_next   = keyok_reg;
        inlen_next   = inlen_reg;
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        lenbad_next  = lenbad_reg;
        lenseen_next = lenseen_reg;
        clen_next    = clen_reg;
        bcnt_next    = bcnt_reg;
        broken_next  = broken_reg;
        tag          = TAG_NONE;
        fend         = 1'b0;

        if (s_axis_tuser[0] == CMD_RESTART) begin
            state_next   = S_START;
            cand_next    = METH_ALL;
            tokpos_next  = 4'd0;
            meth_next    = METH_UNKNOWN;
            keypos_next  = 4'd0;
            keyok_next   = 1'b1;
            inlen_next   = 1'b0;
            phase_next   = PH_BLANKS;
            acc_next     = '0;
            lenbad_next  = 1'b0;
            lenseen_next = 1'b0;
            clen_next    = '0;
            bcnt_next    = '0;
            broken_next  = 1'b0;
        end else begin
            unique case (state_reg)
                S_START: begin
                    if (!(b == CH_SP || b == CH_CR || b == CH_LF)) begin
                        cand_next   = cand_step;
                        tokpos_next = tokpos_base + 4'd1;
                        state_next  = S_METHOD;
                        tag         = TAG_METHOD;
                    end
                end
                S_METHOD: begin
                    if (b == CH_SP) begin
                        meth_next  = meth_at_end;
                        state_next = S_URL;
                        tag        = TAG_METHOD;
                        fend       = 1'b1;
                    end else if (b == CH_CR || b == CH_LF) begin
                        state_next = S_ERROR;
                    end else begin
                        cand_next = cand_step;
                        if (tokpos_reg != TOKEN_SAT) begin
                            tokpos_next = tokpos_reg + 4'd1;
                        end
                        tag = TAG_METHOD;
                    end
                end
                S_URL: begin
                    if (b == CH_SP) begin
                        state_next = S_PROTO;
                        tag        = TAG_URL;
                        fend       = 1'b1;
                    end else if (b == CH_CR || b == CH_LF) begin
                        state_next = S_ERROR;
                    end else begin
                        tag = TAG_URL;
                    end
                end
                S_PROTO: begin
                    tag = TAG_PROTOCOL;
                    if (b == CH_CR) begin
                        state_next = S_PROTO_CR;
                        fend       = 1'b1;
                    end else if (b == CH_LF) begin
                        state_next = S_HDR_START;
                        fend       = 1'b1;
                    end
                end
                S_PROTO_CR, S_VALUE_CR: begin
                    state_next = (b == CH_LF) ? S_HDR_START : S_ERROR;
                end
                S_HDR_START: begin
                    if (b == CH_CR) begin
                        state_next = S_HDR_START_CR;
                    end else begin
                        keypos_next = key_step_ok ? keypos_base + 4'd1 : keypos_base;
                        keyok_next  = key_step_ok;
                        state_next  = S_KEY;
                        tag         = TAG_KEY;
                    end
                end
                S_HDR_START_CR: begin
                    if (b != CH_LF || (lenseen_reg && lenbad_reg)) begin
                        state_next = S_ERROR;
                    end else if (clen_reg != '0) begin
                        bcnt_next  = '0;
                        state_next = S_BODY;
                    end else begin
                        state_next = S_COMPLETE;
                    end
                end
                S_KEY: begin
                    if (b == CH_COLON) begin
                        inlen_next  = keyok_reg && (keypos_reg == KEY_LEN);
                        phase_next  = PH_BLANKS;
                        acc_next    = '0;
                        broken_next = 1'b0;
                        state_next  = S_VALUE;
                        tag         = TAG_KEY;
                        fend        = 1'b1;
                    end else if (b == CH_CR || b == CH_LF) begin
                        state_next = S_ERROR;
                    end else begin
                        keypos_next = key_step_ok ? keypos_reg + 4'd1 : keypos_reg;
                        keyok_next  = key_step_ok;
                        tag         = TAG_KEY;
                    end
                end
                S_VALUE: begin
                    tag = TAG_VALUE;
                    if (b == CH_CR || b == CH_LF) begin
                        if (inlen_reg) begin
                            lenseen_next = 1'b1;
                            lenbad_next  = broken_reg || phase_reg == PH_BLANKS ||
                                           phase_reg == PH_SIGN;
                            clen_next    = acc_reg;
                            inlen_next   = 1'b0;
                        end
                        state_next = (b == CH_CR) ? S_VALUE_CR : S_HDR_START;
                        fend       = 1'b1;
                    end else if (inlen_reg) begin
                        unique case (phase_reg)
                            PH_BLANKS: begin
                                if (b == CH_SP || b == CH_TAB || b == CH_VT || b == CH_FF) begin
                                    phase_next = PH_BLANKS;
                                end else if (b == CH_PLUS) begin
                                    phase_next = PH_SIGN;
                                end else if (!is_digit) begin
                                    broken_next = 1'b1;
                                    phase_next  = PH_REST;
                                end else begin
                                    if (acc_ovf) broken_next = 1'b1;
                                    else acc_next = acc_wide[LB-1:0];
                                    phase_next = PH_DIGITS;
                                end
                            end
                            PH_SIGN: begin
                                if (!is_digit) begin
                                    broken_next = 1'b1;
                                    phase_next  = PH_REST;
                                end else begin
                                    if (acc_ovf) broken_next = 1'b1;
                                    else acc_next = acc_wide[LB-1:0];
                                    phase_next = PH_DIGITS;
                                end
                            end
                            PH_DIGITS: begin
                                if (!is_digit) begin
                                    phase_next = PH_REST;
                                end else begin
                                    if (acc_ovf) broken_next = 1'b1;
                                    else acc_next = acc_wide[LB-1:0];
                                end
                            end
                            default: begin
                                phase_next = PH_REST;
                            end
                        endcase
                    end
                end
                S_BODY: begin
                    bcnt_next = bcnt_inc;
                    tag       = TAG_BODY;
                    if (bcnt_inc >= clen_reg) begin
                        state_next = S_COMPLETE;
                        fend       = 1'b1;
                    end
                end
                default: begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    assign blen = (state_next == S_BODY || state_next == S_COMPLETE) ? clen_low : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_START;
            cand_reg    <= METH_ALL;
            tokpos_reg  <= 4'd0;
            meth_reg    <= METH_UNKNOWN;
            keypos_reg  <= 4'd0;
            keyok_reg   <= 1'b1;
            inlen_reg   <= 1'b0;
            phase_reg   <= PH_BLANKS;
            acc_reg     <= '0;
            lenbad_reg  <= 1'b0;
            lenseen_reg <= 1'b0;
            clen_reg    <= '0;
            bcnt_reg    <= '0;
            broken_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                state_reg   <= state_next;
                cand_reg    <= cand_next;
                tokpos_reg  <= tokpos_next;
                meth_reg    <= meth_next;
                keypos_reg  <= keypos_next;
                keyok_reg   <= keyok_next;
                inlen_reg   <= inlen_next;
                phase_reg   <= phase_next;
                acc_reg     <= acc_next;
                lenbad_reg  <= lenbad_next;
                lenseen_reg <= lenseen_next;
                clen_reg    <= clen_next;
                bcnt_reg    <= bcnt_next;
                broken_reg  <= broken_next;
            end
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            o_status_reg <= status_code(state_next);
            o_tag_reg    <= tag;
            o_fend_reg   <= fend;
            o_meth_reg   <= meth_next;
            o_blen_reg   <= blen;
            o_done_reg   <= (state_next == S_COMPLETE);
            o_err_reg    <= (state_next == S_ERROR);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, o_err_reg, o_done_reg, o_blen_reg, o_meth_reg,
                            o_fend_reg, o_tag_reg, o_status_reg};

`ifndef NO_ASSERTIONS
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_axis_tuser[0] == CMD_RESTART) |=>
            (o_status_reg == STAT_START && o_tag_reg == TAG_NONE && o_meth_reg == METH_UNKNOWN))
        else $error("restart did not clear the result");
    a_body_count_below_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BODY) |-> (bcnt_reg < clen_reg))
        else $error("body count reached content length inside body");
    a_end_has_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && o_fend_reg) |-> (o_tag_reg != TAG_NONE))
        else $error("field end without a field tag");
    a_blen_only_late: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && o_status_reg != STAT_BODY && o_status_reg != STAT_COMPLETE)
            |-> (o_blen_reg == 32'd0))
        else $error("body length shown before end of headers");
    a_done_err_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(o_done_reg && o_err_reg))
        else $error("complete and error flagged together");
`endif

endmodule
